[rtl/hfmb_pkg.sv]
`default_nettype none

package hfmb_pkg;

  localparam int IDX_W  = 3;
  localparam int BC_W   = 4;
  localparam int VAL_W  = 32;
  localparam int EN_W   = 48;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 64;

  localparam logic signed [ACC_W-1:0] FOCK_MAX =
    {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] FOCK_MIN = ~FOCK_MAX;
  localparam logic signed [ACC_W-1:0] EN_MAX =
    {{(ACC_W-EN_W+1){1'b0}}, {(EN_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] EN_MIN = ~EN_MAX;

  typedef enum logic [1:0] {
    OP_LOAD_H   = 2'd0,
    OP_LOAD_ERI = 2'd1,
    OP_LOAD_P   = 2'd2,
    OP_COMPUTE  = 2'd3
  } hfmb_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_SUM,
    ST_CLIP,
    ST_EMUL,
    ST_ETERM,
    ST_EACC,
    ST_EMIT
  } hfmb_state_e;

  typedef struct packed {
    hfmb_op_e                 op;
    logic [IDX_W-1:0]         idx_i;
    logic [IDX_W-1:0]         idx_j;
    logic [IDX_W-1:0]         idx_k;
    logic [IDX_W-1:0]         idx_l;
    logic signed [VAL_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  fock_value;
    logic signed [EN_W-1:0]   energy;
    logic                     saturated;
    logic                     last;
  } out_res_t;

  // Control from the sequencer to the step datapath.
  typedef struct packed {
    logic vld;
    logic clear;
  } step_ctl_t;

endpackage

`default_nettype wire

[rtl/hartree_fock_matrix_build.sv]
`default_nettype none

// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i                cfg_wdata_i (basis count)
// in        in         in_valid_i / in_stall_o in_req_i  (hfmb_pkg::in_req_t)
// out       out        out_valid_o/ out_stall_i out_res_o (hfmb_pkg::out_res_t)
//
// A load request is taken while idle and writes one memory word.
// A compute request walks the integral memory one (k,l) pair per cycle. Each
// Fock entry reads n*n pairs, then drains the step pipe, adds H, clips and
// forms its energy terms before it waits for the output to be free.
// Input requests stall for the whole compute; a held result delays the next entry.
// Reset clears control state and the energy; the stores are undefined until loaded.

module hartree_fock_matrix_build #(
  parameter int MAX_BASIS = 8,
  parameter int FRAC_BITS = 20
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire logic [hfmb_pkg::BC_W-1:0]    cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire hfmb_pkg::in_req_t            in_req_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output hfmb_pkg::out_res_t                out_res_o
);

  localparam int HDEPTH = MAX_BASIS * MAX_BASIS;
  localparam int EDEPTH = HDEPTH * HDEPTH;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int MQ_W   = hfmb_pkg::PROD_W - FRAC_BITS;
  localparam int IW     = hfmb_pkg::IDX_W;
  localparam int VW     = hfmb_pkg::VAL_W;
  localparam int AW     = hfmb_pkg::ACC_W;

  function automatic logic [HAW-1:0] pair_addr(input logic [IW-1:0] x,
                                               input logic [IW-1:0] y);
    return HAW'(int'(x) * MAX_BASIS + int'(y));
  endfunction

  function automatic logic [EAW-1:0] quad_addr(input logic [IW-1:0] x,
                                               input logic [IW-1:0] y,
                                               input logic [IW-1:0] z,
                                               input logic [IW-1:0] w);
    return EAW'(((int'(x) * MAX_BASIS + int'(y)) * MAX_BASIS + int'(z))
                * MAX_BASIS + int'(w));
  endfunction

  hfmb_pkg::hfmb_state_e state_q, state_d;

  logic [hfmb_pkg::BC_W-1:0] basis_q;
  logic [IW-1:0]             nm1, nm1_q;
  logic [IW-1:0]             r_q, c_q, a_q, b_q;
  logic                      rd_vld_q;

  logic                      in_fire, start, issue, step_last, entry_last, emit_ok;
  logic                      idx_ij_ok, idx_kl_ok;
  logic                      we_h, we_eri, we_p;
  hfmb_pkg::step_ctl_t       step_ctl;
  logic                      pipe_busy;
  logic signed [AW-1:0]      acc;

  logic signed [VW-1:0]      h_mem   [HDEPTH];
  logic signed [VW-1:0]      p_mem   [HDEPTH];
  logic signed [VW-1:0]      eri_mem [EDEPTH];

  logic signed [VW-1:0]      h_q, pcr_q, pba_q, eri_fwd_q, eri_swp_q;
  logic signed [AW-1:0]      fsum_q;
  logic signed [VW-1:0]      f_q;
  logic                      fsat_q;
  logic signed [hfmb_pkg::PROD_W-1:0] ph_q, pf_q;
  logic signed [MQ_W-1:0]    mq_ph, mq_pf;
  logic signed [MQ_W:0]      eterm_q;
  logic signed [AW-1:0]      eacc_q;
  logic signed [hfmb_pkg::EN_W-1:0] en_clip;
  logic                      en_sat;

  logic                      out_vld_q;
  hfmb_pkg::out_res_t        out_q;

  // A basis count of zero acts as one; counts above the limit clip to it.
  always_comb begin
    if (basis_q == '0) begin
      nm1 = '0;
    end else if (basis_q > hfmb_pkg::BC_W'(MAX_BASIS)) begin
      nm1 = IW'(MAX_BASIS - 1);
    end else begin
      nm1 = IW'(basis_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= hfmb_pkg::BC_W'(MAX_BASIS);
    end else if (cfg_we_i) begin
      basis_q <= cfg_wdata_i;
    end
  end

  // Control outputs.
  always_comb begin
    in_stall_o = (state_q != hfmb_pkg::ST_IDLE);
    in_fire    = in_valid_i && !in_stall_o;
    start      = in_fire && (in_req_i.op == hfmb_pkg::OP_COMPUTE);
    issue      = (state_q == hfmb_pkg::ST_WALK);
    step_last  = (a_q == nm1_q) && (b_q == nm1_q);
    entry_last = (r_q == nm1_q) && (c_q == nm1_q);
    emit_ok    = (state_q == hfmb_pkg::ST_EMIT) && (!out_vld_q || !out_stall_i);
    idx_ij_ok  = ({1'b0, in_req_i.idx_i} < hfmb_pkg::BC_W'(MAX_BASIS)) &&
                 ({1'b0, in_req_i.idx_j} < hfmb_pkg::BC_W'(MAX_BASIS));
    idx_kl_ok  = ({1'b0, in_req_i.idx_k} < hfmb_pkg::BC_W'(MAX_BASIS)) &&
                 ({1'b0, in_req_i.idx_l} < hfmb_pkg::BC_W'(MAX_BASIS));
    we_h       = in_fire && (in_req_i.op == hfmb_pkg::OP_LOAD_H) && idx_ij_ok;
    we_p       = in_fire && (in_req_i.op == hfmb_pkg::OP_LOAD_P) && idx_ij_ok;
    we_eri     = in_fire && (in_req_i.op == hfmb_pkg::OP_LOAD_ERI) &&
                 idx_ij_ok && idx_kl_ok;
    step_ctl.vld   = rd_vld_q;
    step_ctl.clear = start || (emit_ok && !entry_last);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hfmb_pkg::ST_IDLE:  if (start) state_d = hfmb_pkg::ST_WALK;
      hfmb_pkg::ST_WALK:  if (step_last) state_d = hfmb_pkg::ST_DRAIN;
      hfmb_pkg::ST_DRAIN: if (!rd_vld_q && !pipe_busy) state_d = hfmb_pkg::ST_SUM;
      hfmb_pkg::ST_SUM:   state_d = hfmb_pkg::ST_CLIP;
      hfmb_pkg::ST_CLIP:  state_d = hfmb_pkg::ST_EMUL;
      hfmb_pkg::ST_EMUL:  state_d = hfmb_pkg::ST_ETERM;
      hfmb_pkg::ST_ETERM: state_d = hfmb_pkg::ST_EACC;
      hfmb_pkg::ST_EACC:  state_d = hfmb_pkg::ST_EMIT;
      hfmb_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_d = entry_last ? hfmb_pkg::ST_IDLE : hfmb_pkg::ST_WALK;
        end
      end
      default: state_d = hfmb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hfmb_pkg::ST_IDLE;
      nm1_q    <= '0;
      r_q      <= '0;
      c_q      <= '0;
      a_q      <= '0;
      b_q      <= '0;
      rd_vld_q <= 1'b0;
      eacc_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (start) begin
        nm1_q  <= nm1;
        r_q    <= '0;
        c_q    <= '0;
        a_q    <= '0;
        b_q    <= '0;
        eacc_q <= '0;
      end else begin
        if (issue) begin
          if (b_q == nm1_q) begin
            b_q <= '0;
            a_q <= (a_q == nm1_q) ? '0 : a_q + 1'b1;
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
        if (emit_ok && !entry_last) begin
          if (c_q == nm1_q) begin
            c_q <= '0;
            r_q <= r_q + 1'b1;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        if (state_q == hfmb_pkg::ST_EACC) begin
          eacc_q <= eacc_q + AW'(eterm_q);
        end
      end
    end
  end

  // Loads and compute never overlap, so a read never meets a write in flight.
  always_ff @(posedge clk_i) begin
    if (we_h) begin
      h_mem[pair_addr(in_req_i.idx_i, in_req_i.idx_j)] <= in_req_i.value;
    end
    h_q <= h_mem[pair_addr(r_q, c_q)];
  end

  always_ff @(posedge clk_i) begin
    if (we_p) begin
      p_mem[pair_addr(in_req_i.idx_i, in_req_i.idx_j)] <= in_req_i.value;
    end
    pba_q <= p_mem[pair_addr(b_q, a_q)];
    pcr_q <= p_mem[pair_addr(c_q, r_q)];
  end

  always_ff @(posedge clk_i) begin
    if (we_eri) begin
      eri_mem[quad_addr(in_req_i.idx_i, in_req_i.idx_j, in_req_i.idx_k,
                        in_req_i.idx_l)] <= in_req_i.value;
    end
    eri_fwd_q <= eri_mem[quad_addr(r_q, c_q, a_q, b_q)];
    eri_swp_q <= eri_mem[quad_addr(r_q, b_q, a_q, c_q)];
  end

  hfmb_step_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_step_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (step_ctl),
    .eri_fwd_i (eri_fwd_q),
    .eri_swp_i (eri_swp_q),
    .dens_i    (pba_q),
    .acc_o     (acc),
    .busy_o    (pipe_busy)
  );

  // Entry finishing: add H, clip, then the two energy products of this entry.
  assign mq_ph = MQ_W'(ph_q >>> FRAC_BITS);
  assign mq_pf = MQ_W'(pf_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (state_q == hfmb_pkg::ST_SUM) begin
      fsum_q <= acc + AW'(h_q);
    end
    if (state_q == hfmb_pkg::ST_CLIP) begin
      if (fsum_q > hfmb_pkg::FOCK_MAX) begin
        f_q    <= VW'(hfmb_pkg::FOCK_MAX);
        fsat_q <= 1'b1;
      end else if (fsum_q < hfmb_pkg::FOCK_MIN) begin
        f_q    <= VW'(hfmb_pkg::FOCK_MIN);
        fsat_q <= 1'b1;
      end else begin
        f_q    <= VW'(fsum_q);
        fsat_q <= 1'b0;
      end
    end
    if (state_q == hfmb_pkg::ST_EMUL) begin
      ph_q <= hfmb_pkg::PROD_W'(pcr_q * h_q);
      pf_q <= hfmb_pkg::PROD_W'(pcr_q * f_q);
    end
    if (state_q == hfmb_pkg::ST_ETERM) begin
      eterm_q <= {mq_ph[MQ_W-1], mq_ph} + {mq_pf[MQ_W-1], mq_pf};
    end
  end

  always_comb begin
    if (eacc_q > hfmb_pkg::EN_MAX) begin
      en_clip = hfmb_pkg::EN_W'(hfmb_pkg::EN_MAX);
      en_sat  = 1'b1;
    end else if (eacc_q < hfmb_pkg::EN_MIN) begin
      en_clip = hfmb_pkg::EN_W'(hfmb_pkg::EN_MIN);
      en_sat  = 1'b1;
    end else begin
      en_clip = hfmb_pkg::EN_W'(eacc_q);
      en_sat  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_ok) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      out_q.row        <= r_q;
      out_q.col        <= c_q;
      out_q.fock_value <= f_q;
      out_q.energy     <= entry_last ? en_clip : '0;
      out_q.saturated  <= fsat_q | (entry_last & en_sat);
      out_q.last       <= entry_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

[rtl/hfmb_step_pipe.sv]
`default_nettype none

module hfmb_step_pipe #(
  parameter int FRAC_BITS = 20
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire hfmb_pkg::step_ctl_t                   ctl_i,
  input  wire logic signed [hfmb_pkg::VAL_W-1:0]     eri_fwd_i,
  input  wire logic signed [hfmb_pkg::VAL_W-1:0]     eri_swp_i,
  input  wire logic signed [hfmb_pkg::VAL_W-1:0]     dens_i,
  output logic signed [hfmb_pkg::ACC_W-1:0]          acc_o,
  output logic                                       busy_o
);

  localparam int MQ_W   = hfmb_pkg::PROD_W - FRAC_BITS;
  localparam int TERM_W = MQ_W + 2;

  logic                                   s2_vld_q, s3_vld_q;
  logic signed [hfmb_pkg::PROD_W-1:0]     prod_fwd_q, prod_swp_q;
  logic signed [MQ_W-1:0]                 mq_fwd, mq_swp;
  logic signed [TERM_W-1:0]               term_d, term_q;
  logic signed [hfmb_pkg::ACC_W-1:0]      acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= ctl_i.vld;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_fwd_q <= hfmb_pkg::PROD_W'(eri_fwd_i * dens_i);
    prod_swp_q <= hfmb_pkg::PROD_W'(eri_swp_i * dens_i);
  end

  // Arithmetic shift floors toward minus infinity; the doubling comes after it.
  assign mq_fwd = MQ_W'(prod_fwd_q >>> FRAC_BITS);
  assign mq_swp = MQ_W'(prod_swp_q >>> FRAC_BITS);
  assign term_d = {mq_fwd[MQ_W-1], mq_fwd, 1'b0} - {{2{mq_swp[MQ_W-1]}}, mq_swp};

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (s3_vld_q) begin
      acc_q <= acc_q + hfmb_pkg::ACC_W'(term_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = s2_vld_q | s3_vld_q;

endmodule

`default_nettype wire

[verif/tb_hartree_fock_matrix_build.sv]
`timescale 1ns / 100ps

module tb_hartree_fock_matrix_build;

  localparam int MAX_BASIS     = 8;
  localparam int FRAC_BITS     = 20;
  localparam int FILL_BASIS    = 4;
  localparam int RANDOM_ITEMS  = 176;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 32;
  localparam int PRESSURE_PHASE = 2;

  // Predicts the Fock matrix and energy from its own copy of the three stores.
  class fock_scoreboard;
    int core_h[MAX_BASIS*MAX_BASIS];
    int integral[MAX_BASIS*MAX_BASIS*MAX_BASIS*MAX_BASIS];
    int density[MAX_BASIS*MAX_BASIS];
    logic [hfmb_pkg::BC_W-1:0] basis_raw = 4'd8;
    hfmb_pkg::out_res_t fock_q[$];
    int errors = 0;

    function void set_basis(logic [hfmb_pkg::BC_W-1:0] raw);
      basis_raw = raw;
    endfunction

    function int pending();
      return fock_q.size();
    endfunction

    function int slot(int i, int j, int k, int l);
      return ((i*MAX_BASIS + j)*MAX_BASIS + k)*MAX_BASIS + l;
    endfunction

    // Exact product, then an arithmetic shift that rounds toward minus infinity.
    function longint scaled_product(int a, int b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return prod >>> FRAC_BITS;
    endfunction

    function void note_request(hfmb_pkg::in_req_t req);
      int n;
      int f;
      int p;
      longint acc;
      longint en;
      longint en_out;
      logic sat;
      hfmb_pkg::out_res_t entry;
      case (req.op)
        hfmb_pkg::OP_LOAD_H: core_h[{req.idx_i, req.idx_j}] = req.value;
        hfmb_pkg::OP_LOAD_ERI:
          integral[slot(req.idx_i, req.idx_j, req.idx_k, req.idx_l)] = req.value;
        hfmb_pkg::OP_LOAD_P: density[{req.idx_i, req.idx_j}] = req.value;
        default: begin
          n = (basis_raw == 0) ? 1 : (basis_raw > MAX_BASIS) ? MAX_BASIS : int'(basis_raw);
          en = 0;
          for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
              acc = core_h[r*MAX_BASIS + c];
              for (int a = 0; a < n; a++) begin
                for (int b = 0; b < n; b++) begin
                  p = density[b*MAX_BASIS + a];
                  acc += 2 * scaled_product(integral[slot(r, c, a, b)], p);
                  acc -= scaled_product(integral[slot(r, b, a, c)], p);
                end
              end
              sat = 1'b0;
              if (acc > hfmb_pkg::FOCK_MAX) begin
                acc = hfmb_pkg::FOCK_MAX;
                sat = 1'b1;
              end
              if (acc < hfmb_pkg::FOCK_MIN) begin
                acc = hfmb_pkg::FOCK_MIN;
                sat = 1'b1;
              end
              f = int'(acc);
              // The energy uses the clipped entry, as emitted.
              p = density[c*MAX_BASIS + r];
              en += scaled_product(p, core_h[r*MAX_BASIS + c]) + scaled_product(p, f);
              entry = '0;
              entry.row = r[hfmb_pkg::IDX_W-1:0];
              entry.col = c[hfmb_pkg::IDX_W-1:0];
              entry.fock_value = f;
              if (r == n - 1 && c == n - 1) begin
                en_out = en;
                if (en_out > hfmb_pkg::EN_MAX) begin
                  en_out = hfmb_pkg::EN_MAX;
                  sat = 1'b1;
                end
                if (en_out < hfmb_pkg::EN_MIN) begin
                  en_out = hfmb_pkg::EN_MIN;
                  sat = 1'b1;
                end
                entry.energy = en_out[hfmb_pkg::EN_W-1:0];
                entry.last = 1'b1;
              end
              entry.saturated = sat;
              fock_q.push_back(entry);
            end
          end
        end
      endcase
    endfunction

    function void report_field(string field, logic signed [63:0] want,
                               logic signed [63:0] seen);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
      errors++;
    endfunction

    function void check_result(hfmb_pkg::out_res_t got);
      hfmb_pkg::out_res_t want;
      if (fock_q.size() == 0) begin
        $display("%0t: unexpected Fock entry, got row %0d col %0d value %0d", $time,
                 got.row, got.col, got.fock_value);
        errors++;
        return;
      end
      want = fock_q.pop_front();
      if (got.row !== want.row) report_field("row", want.row, got.row);
      if (got.col !== want.col) report_field("col", want.col, got.col);
      if (got.fock_value !== want.fock_value)
        report_field("fock_value", want.fock_value, got.fock_value);
      if (got.energy !== want.energy) report_field("energy", want.energy, got.energy);
      if (got.saturated !== want.saturated)
        report_field("saturated", want.saturated, got.saturated);
      if (got.last !== want.last) report_field("last", want.last, got.last);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [hfmb_pkg::BC_W-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  hfmb_pkg::in_req_t         in_req_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  hfmb_pkg::out_res_t        out_res_o;

  logic calm = 1'b0;
  int   hold_trigger = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  fock_scoreboard fock_sb = new;

  hartree_fock_matrix_build dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) fock_sb.check_result(out_res_o);
  end

  function automatic hfmb_pkg::in_req_t make_request(hfmb_pkg::hfmb_op_e op, int i, int j,
                                                     int k, int l, int value);
    hfmb_pkg::in_req_t req;
    req.op = op;
    req.idx_i = i[hfmb_pkg::IDX_W-1:0];
    req.idx_j = j[hfmb_pkg::IDX_W-1:0];
    req.idx_k = k[hfmb_pkg::IDX_W-1:0];
    req.idx_l = l[hfmb_pkg::IDX_W-1:0];
    req.value = value;
    return req;
  endfunction

  function automatic int pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return int'($urandom_range(32)) - 16;
      3, 4: return $urandom();
      default: return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // Mostly indices that a compute reads, now and then any index.
  function automatic int pick_index();
    if ($urandom_range(3) == 0) return int'($urandom_range(MAX_BASIS - 1));
    return int'($urandom_range(FILL_BASIS - 1));
  endfunction

  function automatic hfmb_pkg::in_req_t random_load();
    hfmb_pkg::hfmb_op_e op;
    op = hfmb_pkg::hfmb_op_e'($urandom_range(2));
    return make_request(op, pick_index(), pick_index(), pick_index(), pick_index(),
                        pick_value());
  endfunction

  // A compute request carries junk in the fields it ignores.
  function automatic hfmb_pkg::in_req_t random_compute();
    return make_request(hfmb_pkg::OP_COMPUTE, $urandom_range(7), $urandom_range(7),
                        $urandom_range(7), $urandom_range(7), $urandom());
  endfunction

  // Sizes up to the filled corner; a count of zero acts as one.
  function automatic logic [hfmb_pkg::BC_W-1:0] pick_basis();
    case ($urandom_range(7))
      0: return 4'd0;
      default: return hfmb_pkg::BC_W'($urandom_range(FILL_BASIS, 1));
    endcase
  endfunction

  task automatic send_request(hfmb_pkg::in_req_t req);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    fock_sb.note_request(req);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (fock_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_basis(logic [hfmb_pkg::BC_W-1:0] raw);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fock_sb.set_basis(raw);
  endtask

  initial begin
    int random_sent;
    int phase;
    int burst;
    random_sent = 0;
    phase = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single basis function: clipping both ways and floor rounding.
    write_basis(4'd1);
    send_request(make_request(hfmb_pkg::OP_LOAD_H, 0, 0, 7, 7, 32'h7FFF_FFFF));
    send_request(make_request(hfmb_pkg::OP_LOAD_ERI, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send_request(make_request(hfmb_pkg::OP_LOAD_P, 0, 0, 5, 2, 32'h7FFF_FFFF));
    send_request(make_request(hfmb_pkg::OP_COMPUTE, 7, 7, 7, 7, 32'hFFFF_FFFF));
    send_request(make_request(hfmb_pkg::OP_LOAD_P, 0, 0, 0, 0, 32'h8000_0000));
    send_request(make_request(hfmb_pkg::OP_COMPUTE, 0, 0, 0, 0, 0));
    send_request(make_request(hfmb_pkg::OP_LOAD_H, 0, 0, 2, 5, 32'h8000_0000));
    send_request(make_request(hfmb_pkg::OP_LOAD_ERI, 0, 0, 0, 0, 32'h8000_0000));
    send_request(make_request(hfmb_pkg::OP_LOAD_P, 0, 0, 7, 0, 32'h8000_0000));
    send_request(make_request(hfmb_pkg::OP_COMPUTE, 3, 4, 1, 6, 32'h1234_5678));
    send_request(make_request(hfmb_pkg::OP_LOAD_H, 0, 0, 0, 7, 1));
    send_request(make_request(hfmb_pkg::OP_LOAD_ERI, 0, 0, 0, 0, -1));
    send_request(make_request(hfmb_pkg::OP_LOAD_P, 0, 0, 7, 7, 1));
    send_request(make_request(hfmb_pkg::OP_COMPUTE, 0, 7, 0, 7, 32'h8000_0000));
    wait_quiet();
    write_basis(4'd0);
    send_request(random_compute());

    // Fill the corner that later computes read. The most negative H and P with
    // positive integrals clip every entry low and push the energy past its top.
    wait_quiet();
    write_basis(hfmb_pkg::BC_W'(FILL_BASIS));
    for (int i = 0; i < FILL_BASIS; i++) begin
      for (int j = 0; j < FILL_BASIS; j++) begin
        send_request(make_request(hfmb_pkg::OP_LOAD_H, i, j, $urandom_range(7),
                                  $urandom_range(7), 32'h8000_0000));
        send_request(make_request(hfmb_pkg::OP_LOAD_P, i, j, $urandom_range(7),
                                  $urandom_range(7), 32'h8000_0000));
        for (int k = 0; k < FILL_BASIS; k++) begin
          for (int l = 0; l < FILL_BASIS; l++) begin
            send_request(make_request(hfmb_pkg::OP_LOAD_ERI, i, j, k, l,
                                      int'($urandom_range(1024, 512))));
          end
        end
      end
    end
    send_request(random_compute());

    while (random_sent < RANDOM_ITEMS) begin
      wait_quiet();
      calm <= (phase >= 4 && phase < 8);
      write_basis(phase == PRESSURE_PHASE ? 4'd3 : pick_basis());
      burst = $urandom_range(16, 4);
      repeat (burst) begin
        send_request(random_load());
        random_sent++;
      end
      send_request(random_compute());
      random_sent++;
      if (phase == PRESSURE_PHASE) begin
        // Results are held back while load requests pile up behind the compute.
        hold_trigger <= hold_trigger + 1;
        repeat (24) begin
          send_request(random_load());
          random_sent++;
        end
      end else if ($urandom_range(3) == 0) begin
        send_request(random_compute());
        random_sent++;
      end
      phase++;
    end

    wait_quiet();
    if (fock_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
